FILE: rtl/sized_block_recycler_assert.svh
// assertion macros used by the checker file of the size-sorted block recycler
// no dependencies; take in with an include of the bare file name
`ifndef SIZED_BLOCK_RECYCLER_ASSERT_SVH
`define SIZED_BLOCK_RECYCLER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sbr check failed");

// next-cycle implication, disabled while reset is low
`define SBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sbr check failed");

`endif

FILE: rtl/sbr_pkg.sv
// types, codes and constants of the size-sorted block recycler
// no dependencies; used by every other file of the block but the assertion macro header
package sbr_pkg;

    localparam int SIZE_W          = 32;
    localparam int FIELD_ADDR_W    = 32;
    localparam int THR_W           = 16;
    localparam int STATUS_W        = 3;
    localparam int CAPACITY_DEF    = 64;
    localparam int ADDR_WIDTH_DEF  = 32;
    localparam int FIT_FACTOR      = 2;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd256;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT    = 3'd0,
        ST_MISS   = 3'd1,
        ST_BYPASS = 3'd2,
        ST_STORED = 3'd3,
        ST_SMALL  = 3'd4,
        ST_FULL   = 3'd5
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic cmp;      // compare the incoming size against the stored one
        logic ins;      // insert shift toward the tail
        logic rem;      // remove shift toward the head
        logic none_ge;  // no stored entry is at least the request
    } t_cell_ctl;

endpackage

FILE: rtl/sbr_if.sv
// request and response channel interfaces of the size-sorted block recycler
// depends on sbr_pkg for field widths
interface sbr_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [sbr_pkg::SIZE_W-1:0]        req_size;
    logic [sbr_pkg::FIELD_ADDR_W-1:0]  block_addr;

    modport source (output valid, output operation, output req_size, output block_addr,
                    input ready);
    modport sink   (input valid, input operation, input req_size, input block_addr,
                    output ready);
endinterface

interface sbr_out_if;
    logic                              valid;
    logic                              ready;
    logic [sbr_pkg::STATUS_W-1:0]      status;
    logic [sbr_pkg::FIELD_ADDR_W-1:0]  grant_addr;
    logic [sbr_pkg::SIZE_W-1:0]        grant_size;

    modport source (output valid, output status, output grant_addr, output grant_size,
                    input ready);
    modport sink   (input valid, input status, input grant_addr, input grant_size,
                    output ready);
endinterface

FILE: rtl/sbr_cell.sv
// one entry cell of the sorted chain: holds size and address, compares and shifts
// depends on sbr_pkg
module sbr_cell #(
    parameter int ADDR_WIDTH = sbr_pkg::ADDR_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbr_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_valid,
    input  logic                        i_at_end,
    input  logic [sbr_pkg::SIZE_W-1:0]  i_cmp_size,
    input  logic [sbr_pkg::SIZE_W-1:0]  i_new_size,
    input  logic [ADDR_WIDTH-1:0]       i_new_addr,
    input  logic                        i_left_ge,
    input  logic [sbr_pkg::SIZE_W-1:0]  i_left_size,
    input  logic [ADDR_WIDTH-1:0]       i_left_addr,
    input  logic [sbr_pkg::SIZE_W-1:0]  i_right_size,
    input  logic [ADDR_WIDTH-1:0]       i_right_addr,
    output logic [sbr_pkg::SIZE_W-1:0]  o_size,
    output logic [ADDR_WIDTH-1:0]       o_addr,
    output logic                        o_ge,
    output logic                        o_hit_fit,
    output logic [sbr_pkg::SIZE_W-1:0]  o_sel_size,
    output logic [ADDR_WIDTH-1:0]       o_sel_addr
);

    logic [sbr_pkg::SIZE_W-1:0] r_size;
    logic [ADDR_WIDTH-1:0]      r_addr;
    logic                       r_ge;
    logic                       r_fit;
    logic                       w_first;
    logic [sbr_pkg::SIZE_W:0]   w_limit;

    // twice the request at full precision
    assign w_limit = (sbr_pkg::SIZE_W+1)'(i_cmp_size) * (sbr_pkg::SIZE_W+1)'(sbr_pkg::FIT_FACTOR);
    assign w_first = r_ge && !i_left_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ge  <= 1'b0;
            r_fit <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_ge  <= i_valid && (r_size >= i_cmp_size);
            r_fit <= {1'b0, r_size} <= w_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_left_ge) begin
                r_size <= i_left_size;
                r_addr <= i_left_addr;
            end else if (w_first || (i_at_end && i_ctl.none_ge)) begin
                r_size <= i_new_size;
                r_addr <= i_new_addr;
            end
        end else if (i_ctl.rem && r_ge) begin
            r_size <= i_right_size;
            r_addr <= i_right_addr;
        end
    end

    assign o_size     = r_size;
    assign o_addr     = r_addr;
    assign o_ge       = r_ge;
    assign o_hit_fit  = w_first && r_fit;
    assign o_sel_size = w_first ? r_size : '0;
    assign o_sel_addr = w_first ? r_addr : '0;

endmodule

FILE: rtl/sized_block_recycler.sv
// size-sorted block recycler with bounded best-fit reuse, top level
// depends on sbr_pkg, sbr_if (sbr_in_if, sbr_out_if) and sbr_cell
//
// keeps up to CAPACITY returned blocks as (size, address) pairs in a chain of
// cells sorted by ascending size. a free beat at or above the threshold is
// inserted before the first entry of equal or larger size; an allocate beat
// at or above the threshold takes the first entry that is at least the request
// if that entry is no more than twice the request, else it misses. beats below
// the threshold bypass the table. a free into a full table is dropped with the
// full status. every beat gives exactly one response beat. each item passes the
// idle and update states: on the accept every cell compares its size with the
// request at once, and in the update the chain shifts by one place and the response
// register is loaded; the update waits while the response register still
// holds an unread beat. a new request is taken while a response is pending.
// the threshold register resets to 256 and is written through i_cfg_we.
module sized_block_recycler #(
    parameter int CAPACITY   = sbr_pkg::CAPACITY_DEF,
    parameter int ADDR_WIDTH = sbr_pkg::ADDR_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sbr_pkg::THR_W-1:0]   i_cfg_wdata,
    sbr_in_if.sink                      i_req,
    sbr_out_if.source                   o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    t_state                          r_state;
    logic [sbr_pkg::THR_W-1:0]       r_thr;
    logic [CNT_W-1:0]                r_count;
    sbr_pkg::t_op                    r_op;
    logic [sbr_pkg::SIZE_W-1:0]      r_size;
    logic [ADDR_WIDTH-1:0]           r_addr;
    logic                            r_small;
    logic                            r_out_valid;
    sbr_pkg::t_status                r_status;
    logic [sbr_pkg::FIELD_ADDR_W-1:0] r_gaddr;
    logic [sbr_pkg::SIZE_W-1:0]      r_gsize;

    // per-cell wires of the chain
    logic [sbr_pkg::SIZE_W-1:0] w_size     [CAPACITY];
    logic [ADDR_WIDTH-1:0]      w_addr     [CAPACITY];
    logic [sbr_pkg::SIZE_W-1:0] w_sel_size [CAPACITY];
    logic [ADDR_WIDTH-1:0]      w_sel_addr [CAPACITY];
    logic [CAPACITY-1:0]        w_ge;
    logic [CAPACITY-1:0]        w_hit_fit;

    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_do_upd;
    logic                       w_full;
    logic                       w_hit;
    logic                       w_any_ge;
    logic [sbr_pkg::SIZE_W-1:0] w_gsize;
    logic [ADDR_WIDTH-1:0]      w_gaddr;
    sbr_pkg::t_cell_ctl         w_ctl;
    sbr_pkg::t_status           w_status;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_do_upd    = (r_state == S_UPD) && w_out_free;
    assign w_full      = (r_count == CNT_W'(CAPACITY));

    // one-hot pick of the first cell at least the request; only one cell drives nonzero
    always_comb begin
        w_gsize = '0;
        w_gaddr = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_gsize = w_gsize | w_sel_size[k];
            w_gaddr = w_gaddr | w_sel_addr[k];
        end
    end

    assign w_any_ge = |w_ge;
    assign w_hit    = (r_op == sbr_pkg::OP_ALLOC) && !r_small && (|w_hit_fit);

    always_comb begin
        if (r_op == sbr_pkg::OP_ALLOC) begin
            if (r_small) begin
                w_status = sbr_pkg::ST_BYPASS;
            end else if (w_hit) begin
                w_status = sbr_pkg::ST_HIT;
            end else begin
                w_status = sbr_pkg::ST_MISS;
            end
        end else begin
            if (r_small) begin
                w_status = sbr_pkg::ST_SMALL;
            end else if (w_full) begin
                w_status = sbr_pkg::ST_FULL;
            end else begin
                w_status = sbr_pkg::ST_STORED;
            end
        end
    end

    assign w_ctl.cmp     = w_accept;
    assign w_ctl.ins     = w_do_upd && (w_status == sbr_pkg::ST_STORED);
    assign w_ctl.rem     = w_do_upd && w_hit;
    assign w_ctl.none_ge = !w_any_ge;

    // the sorted chain; cell 0 is the smallest entry
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                       w_left_ge;
        logic [sbr_pkg::SIZE_W-1:0] w_left_size;
        logic [ADDR_WIDTH-1:0]      w_left_addr;
        logic [sbr_pkg::SIZE_W-1:0] w_right_size;
        logic [ADDR_WIDTH-1:0]      w_right_addr;

        if (g == 0) begin : g_head
            assign w_left_ge   = 1'b0;
            assign w_left_size = '0;
            assign w_left_addr = '0;
        end else begin : g_mid
            assign w_left_ge   = w_ge[g-1];
            assign w_left_size = w_size[g-1];
            assign w_left_addr = w_addr[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_size = '0;
            assign w_right_addr = '0;
        end else begin : g_body
            assign w_right_size = w_size[g+1];
            assign w_right_addr = w_addr[g+1];
        end

        sbr_cell #(
            .ADDR_WIDTH (ADDR_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_valid      (CNT_W'(g) < r_count),
            .i_at_end     (CNT_W'(g) == r_count),
            .i_cmp_size   (i_req.req_size),
            .i_new_size   (r_size),
            .i_new_addr   (r_addr),
            .i_left_ge    (w_left_ge),
            .i_left_size  (w_left_size),
            .i_left_addr  (w_left_addr),
            .i_right_size (w_right_size),
            .i_right_addr (w_right_addr),
            .o_size       (w_size[g]),
            .o_addr       (w_addr[g]),
            .o_ge         (w_ge[g]),
            .o_hit_fit    (w_hit_fit[g]),
            .o_sel_size   (w_sel_size[g]),
            .o_sel_addr   (w_sel_addr[g])
        );
    end

    // sequencer, entry count, threshold and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= sbr_pkg::THRESHOLD_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_ctl.ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_ctl.rem) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (w_do_upd) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and response payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= sbr_pkg::t_op'(i_req.operation);
            r_size  <= i_req.req_size;
            r_addr  <= ADDR_WIDTH'(i_req.block_addr);
            r_small <= i_req.req_size < sbr_pkg::SIZE_W'(r_thr);
        end
        if (w_do_upd) begin
            r_status <= w_status;
            r_gaddr  <= w_hit ? sbr_pkg::FIELD_ADDR_W'(w_gaddr) : '0;
            r_gsize  <= w_hit ? w_gsize : r_size;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.grant_addr = r_gaddr;
    assign o_rsp.grant_size = r_gsize;

endmodule

FILE: rtl/sbr_checker.sv
// port-level checks of the size-sorted block recycler, bound to the top level
// depends on sbr_pkg, sbr_if and sized_block_recycler_assert.svh
`include "sized_block_recycler_assert.svh"

module sbr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    sbr_in_if.sink      i_req,
    sbr_out_if.source   o_rsp
);

    logic w_in_beat;
    logic w_stall;
    logic w_not_hit;

    assign w_in_beat = i_req.valid && i_req.ready;
    assign w_stall   = o_rsp.valid && !o_rsp.ready;
    assign w_not_hit = o_rsp.valid && (o_rsp.status != sbr_pkg::ST_HIT);

    // a pending response beat holds until taken
    `SBR_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, w_stall, o_rsp.valid && $stable(o_rsp.grant_size))

    // the update cycle after an accept never takes another request
    `SBR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_beat, !i_req.ready)

    // a fresh response beat comes from the request accepted just before its update
    `SBR_ASSERT_NOW(a_rsp_source, i_clk, i_rst_n, $rose(o_rsp.valid), $past(w_in_beat, 2))

    // only a hit carries an address
    `SBR_ASSERT_NOW(a_addr_on_hit, i_clk, i_rst_n, w_not_hit, o_rsp.grant_addr == '0)

endmodule

bind sized_block_recycler sbr_checker u_sbr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);
